[hw/rtl/spre_pkg.sv]
// ============================================================================
// spre_pkg: shared types, constants and code tables
// Command and result records passed between the encoder stages, queue sizes,
// and the per-mode run-length code table.
// ============================================================================
`default_nettype none

package spre_pkg;

  // Pixel code modes (depth_mode after folding the unused code onto 8-bit)
  localparam logic [1:0] MODE_2BIT = 2'd0;
  localparam logic [1:0] MODE_4BIT = 2'd1;
  localparam logic [1:0] MODE_8BIT = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] MODE_RESET = MODE_8BIT;

  // Run length at which each mode flushes the open run
  localparam logic [8:0] CAP_2BIT = 9'd284;
  localparam logic [8:0] CAP_4BIT = 9'd280;
  localparam logic [8:0] CAP_8BIT = 9'd127;

  // Stream bytes
  localparam logic [7:0] HDR_BASE   = 8'h10;
  localparam logic [7:0] EOL_BYTE   = 8'hF0;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  // 2-bit code table limits and prefixes
  localparam logic [8:0] RUN2_LONG      = 9'd29;
  localparam logic [8:0] RUN2_MID       = 9'd12;
  localparam logic [8:0] RUN2_MID_MAX   = 9'd27;
  localparam logic [8:0] RUN2_SHORT     = 9'd3;
  localparam logic [8:0] RUN2_SHORT_MAX = 9'd10;
  localparam logic [7:0] CODE2_LONG     = 8'h03;
  localparam logic [7:0] CODE2_MID      = 8'h02;
  localparam logic [7:0] CODE2_ONE      = 8'h01;

  // 4-bit code table limits and prefixes
  localparam logic [8:0] RUN4_LONG      = 9'd25;
  localparam logic [8:0] RUN4_MID       = 9'd4;
  localparam logic [8:0] RUN4_MID_CLIP  = 9'd7;
  localparam logic [8:0] RUN4_ZERO_MIN  = 9'd3;
  localparam logic [8:0] RUN4_ZERO_MAX  = 9'd9;
  localparam logic [7:0] CODE4_LONG     = 8'h0f;
  localparam logic [7:0] CODE4_TWO_ZERO = 8'h0d;
  localparam logic [7:0] CODE4_ONE_ZERO = 8'h0c;

  // 8-bit colour-run flag
  localparam logic [7:0] CODE8_COLOUR   = 8'h80;

  // Queue sizes
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Work for one pixel: optional header, up to two run flushes, optional close
  typedef struct packed {
    logic       hdr;
    logic       eol;
    logic [1:0] mode;
    logic       a_vld;
    logic [7:0] a_col;
    logic [8:0] a_cnt;
    logic       b_vld;
    logic [7:0] b_col;
    logic [8:0] b_cnt;
  } cmd_t;

  // One result byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       closed;
  } out_t;

  // One code: up to three bit groups, and how many pixels it covers
  typedef struct packed {
    logic [1:0]       nputs;
    logic [2:0][7:0]  val;
    logic [2:0][3:0]  nbits;
    logic [8:0]       used;
  } code_t;

  // Greedy code choice for the head of a run of len pixels of colour c
  function automatic code_t code_of(input logic [1:0] mode, input logic [7:0] c,
                                    input logic [8:0] len);
    code_t      r;
    logic [8:0] lclip;
    r = '0;
    lclip = (len > RUN4_MID_CLIP) ? RUN4_MID_CLIP : len;
    case (mode)
      MODE_2BIT: begin
        if (len >= RUN2_LONG) begin
          r.nputs = 2'd3; r.used = len;
          r.val[0] = CODE2_LONG;           r.nbits[0] = 4'd6;
          r.val[1] = 8'(len - RUN2_LONG);  r.nbits[1] = 4'd8;
          r.val[2] = c;                    r.nbits[2] = 4'd2;
        end else if (len >= RUN2_MID && len <= RUN2_MID_MAX) begin
          r.nputs = 2'd3; r.used = len;
          r.val[0] = CODE2_MID;            r.nbits[0] = 4'd6;
          r.val[1] = 8'(len - RUN2_MID);   r.nbits[1] = 4'd4;
          r.val[2] = c;                    r.nbits[2] = 4'd2;
        end else if (len >= RUN2_SHORT && len <= RUN2_SHORT_MAX) begin
          r.nputs = 2'd3; r.used = len;
          r.val[0] = 8'h00;                r.nbits[0] = 4'd2;
          r.val[1] = 8'(9'd8 + len - RUN2_SHORT); r.nbits[1] = 4'd4;
          r.val[2] = c;                    r.nbits[2] = 4'd2;
        end else if (c != 8'h00) begin
          r.nputs = 2'd1; r.used = 9'd1;
          r.val[0] = c;                    r.nbits[0] = 4'd2;
        end else if (len == 9'd2) begin
          r.nputs = 2'd1; r.used = 9'd2;
          r.val[0] = CODE2_ONE;            r.nbits[0] = 4'd6;
        end else begin
          r.nputs = 2'd1; r.used = 9'd1;
          r.val[0] = CODE2_ONE;            r.nbits[0] = 4'd4;
        end
      end
      MODE_4BIT: begin
        if (c == 8'h00 && len >= RUN4_ZERO_MIN && len <= RUN4_ZERO_MAX) begin
          r.nputs = 2'd2; r.used = len;
          r.val[0] = 8'h00;                r.nbits[0] = 4'd4;
          r.val[1] = 8'(len - 9'd2);       r.nbits[1] = 4'd4;
        end else if (len >= RUN4_MID && len < RUN4_LONG) begin
          r.nputs = 2'd3; r.used = lclip;
          r.val[0] = 8'h00;                r.nbits[0] = 4'd4;
          r.val[1] = 8'(9'd8 + lclip - RUN4_MID); r.nbits[1] = 4'd4;
          r.val[2] = c;                    r.nbits[2] = 4'd4;
        end else if (len >= RUN4_LONG) begin
          r.nputs = 2'd3; r.used = len;
          r.val[0] = CODE4_LONG;           r.nbits[0] = 4'd8;
          r.val[1] = 8'(len - RUN4_LONG);  r.nbits[1] = 4'd8;
          r.val[2] = c;                    r.nbits[2] = 4'd4;
        end else if (c != 8'h00) begin
          r.nputs = 2'd1; r.used = 9'd1;
          r.val[0] = c;                    r.nbits[0] = 4'd4;
        end else if (len > 9'd1) begin
          r.nputs = 2'd1; r.used = 9'd2;
          r.val[0] = CODE4_TWO_ZERO;       r.nbits[0] = 4'd8;
        end else begin
          r.nputs = 2'd1; r.used = 9'd1;
          r.val[0] = CODE4_ONE_ZERO;       r.nbits[0] = 4'd8;
        end
      end
      default: begin
        if (len == 9'd1 && c != 8'h00) begin
          r.nputs = 2'd1; r.used = 9'd1;
          r.val[0] = c;                    r.nbits[0] = 4'd8;
        end else if (c == 8'h00) begin
          r.nputs = 2'd2; r.used = len;
          r.val[0] = 8'h00;                r.nbits[0] = 4'd8;
          r.val[1] = len[7:0];             r.nbits[1] = 4'd8;
        end else if (len > 9'd2) begin
          r.nputs = 2'd3; r.used = len;
          r.val[0] = 8'h00;                r.nbits[0] = 4'd8;
          r.val[1] = CODE8_COLOUR | len[7:0]; r.nbits[1] = 4'd8;
          r.val[2] = c;                    r.nbits[2] = 4'd8;
        end else begin
          r.nputs = 2'd2; r.used = 9'd2;
          r.val[0] = c;                    r.nbits[0] = 4'd8;
          r.val[1] = c;                    r.nbits[1] = 4'd8;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/subtitle_pixel_rle_encoder.sv]
// ============================================================================
// subtitle_pixel_rle_encoder: subtitle pixel-data run-length encoder
// Encodes palette-index pixels, one line at a time, into the 2-, 4- or 8-bit
// subtitle pixel-data byte stream, with line header and line close bytes.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_push / in_full    | in_pixel[7:0], in_line_end
//  out      | out_pop / out_empty  | out_byte[7:0], out_burst_last, out_line_closed
//  cfg      | cfg_valid / cfg_ready| cfg_depth_mode[1:0]
//
// The front takes one pixel per cycle while its 4-entry command queue has room.
// The back sequencer emits each code as its bit groups (one to three per
// code), closes a line through end-of-string, padding, an extra zero byte in
// 8-bit mode and the close byte, and takes an extra step when a command ends
// on a byte while an earlier byte of it is still held (always so for a line
// close); it pauses while the result queue is full. Reset is synchronous and
// clears queues, run and line state; depth mode returns to 8-bit. Mode writes are dropped while a line is open.
//
`default_nettype none

module subtitle_pixel_rle_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output      logic       in_full,
  input  wire logic [7:0] in_pixel,
  input  wire logic       in_line_end,
  output      logic       out_empty,
  input  wire logic       out_pop,
  output      logic [7:0] out_byte,
  output      logic       out_burst_last,
  output      logic       out_line_closed,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [1:0] cfg_depth_mode
);

  spre_pkg::cmd_t fq_item, bq_item;
  spre_pkg::out_t oq_wr_item, oq_rd_item;
  logic           fq_push, fq_full, bq_pop, bq_empty;
  logic           oq_push, oq_full;

  // Intake and run tracking
  spre_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_pixel       (in_pixel),
    .in_line_end    (in_line_end),
    .in_full        (in_full),
    .cfg_valid      (cfg_valid),
    .cfg_depth_mode (cfg_depth_mode),
    .cfg_ready      (cfg_ready),
    .q_full         (fq_full),
    .q_push         (fq_push),
    .q_item         (fq_item)
  );

  // Decouple intake from encoding
  spre_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_item (fq_item),
    .full    (fq_full),
    .pop     (bq_pop),
    .empty   (bq_empty),
    .rd_item (bq_item)
  );

  // Encode and pack
  spre_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (bq_empty),
    .q_head  (bq_item),
    .q_pop   (bq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_item (oq_wr_item)
  );

  // Hold finished bytes for the consumer
  spre_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_item (oq_wr_item),
    .full    (oq_full),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_item (oq_rd_item)
  );

  assign out_byte        = oq_rd_item.data;
  assign out_burst_last  = oq_rd_item.last;
  assign out_line_closed = oq_rd_item.closed;

endmodule

`default_nettype wire

[hw/rtl/spre_front.sv]
// ============================================================================
// spre_front: pixel intake and run tracking
// Masks each pixel to the mode width, tracks the open run and line state, and
// turns a pixel that opens or closes a line or ends a run into one command.
// ============================================================================
`default_nettype none

module spre_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  input  wire logic [7:0]     in_pixel,
  input  wire logic           in_line_end,
  output      logic           in_full,
  input  wire logic           cfg_valid,
  input  wire logic [1:0]     cfg_depth_mode,
  output      logic           cfg_ready,
  input  wire logic           q_full,
  output      logic           q_push,
  output spre_pkg::cmd_t      q_item
);

  logic [1:0] depth_mode_r, depth_mode_nxt;
  logic       line_open_r, line_open_nxt;
  logic [7:0] run_colour_r, run_colour_nxt;
  logic [8:0] run_count_r, run_count_nxt;

  logic [1:0] mode;
  logic [8:0] cap;
  logic [7:0] pix;
  logic       accept;
  logic [8:0] count0, count1, count2, count3;
  logic       chg, capped;

  // Fold the unused mode code onto 8-bit and pick the run cap
  always_comb begin
    mode = (depth_mode_r >= spre_pkg::MODE_8BIT) ? spre_pkg::MODE_8BIT : depth_mode_r;
    case (mode)
      spre_pkg::MODE_2BIT: begin
        cap = spre_pkg::CAP_2BIT;
        pix = in_pixel & 8'h03;
      end
      spre_pkg::MODE_4BIT: begin
        cap = spre_pkg::CAP_4BIT;
        pix = in_pixel & 8'h0f;
      end
      default: begin
        cap = spre_pkg::CAP_8BIT;
        pix = in_pixel;
      end
    endcase
  end

  // Classify the pixel against the open run
  always_comb begin
    accept = in_push && !q_full;
    count0 = line_open_r ? run_count_r : 9'd0;
    chg    = (count0 != 9'd0) && (pix != run_colour_r);
    count1 = chg ? 9'd0 : count0;
    count2 = count1 + 9'd1;
    capped = (count2 >= cap);
    count3 = capped ? 9'd0 : count2;

    q_item.hdr   = !line_open_r;
    q_item.eol   = in_line_end;
    q_item.mode  = mode;
    q_item.a_vld = chg || capped;
    q_item.a_col = chg ? run_colour_r : pix;
    q_item.a_cnt = chg ? count0 : count2;
    q_item.b_vld = in_line_end && (count3 != 9'd0);
    q_item.b_col = pix;
    q_item.b_cnt = count3;

    // Drop pixels that only extend a run
    q_push    = accept && (q_item.hdr || q_item.a_vld || q_item.eol);
    in_full   = q_full;
    cfg_ready = 1'b1;
  end

  // Advance run and line state
  always_comb begin
    depth_mode_nxt = depth_mode_r;
    line_open_nxt  = line_open_r;
    run_colour_nxt = run_colour_r;
    run_count_nxt  = run_count_r;
    if (cfg_valid && !line_open_r) begin
      depth_mode_nxt = cfg_depth_mode;
    end
    if (accept) begin
      line_open_nxt  = !in_line_end;
      run_colour_nxt = pix;
      run_count_nxt  = in_line_end ? 9'd0 : count3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= spre_pkg::MODE_RESET;
      line_open_r  <= 1'b0;
      run_colour_r <= 8'h00;
      run_count_r  <= 9'd0;
    end else begin
      depth_mode_r <= depth_mode_nxt;
      line_open_r  <= line_open_nxt;
      run_colour_r <= run_colour_nxt;
      run_count_r  <= run_count_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spre_cmdq.sv]
// ============================================================================
// spre_cmdq: command queue between front and back
// Small register queue of per-pixel commands; lets either side stall alone.
// ============================================================================
`default_nettype none

module spre_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spre_pkg::cmd_t wr_item,
  output      logic           full,
  input  wire logic           pop,
  output      logic           empty,
  output spre_pkg::cmd_t      rd_item
);

  localparam logic [spre_pkg::CMDQ_AW-1:0] LAST_SLOT =
    spre_pkg::CMDQ_AW'(spre_pkg::CMDQ_DEPTH - 1);

  spre_pkg::cmd_t                mem_r [spre_pkg::CMDQ_DEPTH];
  logic [spre_pkg::CMDQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [spre_pkg::CMDQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [spre_pkg::CMDQ_CW-1:0]  count_r, count_nxt;
  logic                          do_push, do_pop;

  // Pointer and fill bookkeeping
  always_comb begin
    full    = (count_r == spre_pkg::CMDQ_CW'(spre_pkg::CMDQ_DEPTH));
    empty   = (count_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + spre_pkg::CMDQ_CW'(do_push) - spre_pkg::CMDQ_CW'(do_pop);
    rd_item   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spre_outq.sv]
// ============================================================================
// spre_outq: result byte queue
// Register queue holding encoded bytes until the consumer pops them.
// ============================================================================
`default_nettype none

module spre_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spre_pkg::out_t wr_item,
  output      logic           full,
  input  wire logic           pop,
  output      logic           empty,
  output spre_pkg::out_t      rd_item
);

  localparam logic [spre_pkg::OUTQ_AW-1:0] LAST_SLOT =
    spre_pkg::OUTQ_AW'(spre_pkg::OUTQ_DEPTH - 1);

  spre_pkg::out_t                mem_r [spre_pkg::OUTQ_DEPTH];
  logic [spre_pkg::OUTQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [spre_pkg::OUTQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [spre_pkg::OUTQ_CW-1:0]  count_r, count_nxt;
  logic                          do_push, do_pop;

  // Pointer and fill bookkeeping
  always_comb begin
    full    = (count_r == spre_pkg::OUTQ_CW'(spre_pkg::OUTQ_DEPTH));
    empty   = (count_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + spre_pkg::OUTQ_CW'(do_push) - spre_pkg::OUTQ_CW'(do_pop);
    rd_item   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming byte
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spre_back.sv]
// ============================================================================
// spre_back: code sequencer and bit packer
// Walks each command through its phases, feeds the byte packer one bit group
// per cycle while the result queue has room, and marks each burst's last byte.
// ============================================================================
`default_nettype none

module spre_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire spre_pkg::cmd_t q_head,
  output      logic           q_pop,
  input  wire logic           oq_full,
  output      logic           oq_push,
  output spre_pkg::out_t      oq_item
);

  // Sequencer states: one per command phase, plus idle and a final drain
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HDR   = 4'd1;
  localparam logic [3:0] ST_RUN_A = 4'd2;
  localparam logic [3:0] ST_RUN_B = 4'd3;
  localparam logic [3:0] ST_EOL   = 4'd4;
  localparam logic [3:0] ST_PAD   = 4'd5;
  localparam logic [3:0] ST_ZERO8 = 4'd6;
  localparam logic [3:0] ST_CLOSE = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // Phase that follows st within command c; ST_IDLE means the command is done
  function automatic logic [3:0] next_after(input logic [3:0] st,
                                            input spre_pkg::cmd_t c);
    logic [3:0] r;
    case (st)
      ST_HDR:   r = c.a_vld ? ST_RUN_A : (c.b_vld ? ST_RUN_B : (c.eol ? ST_EOL : ST_IDLE));
      ST_RUN_A: r = c.b_vld ? ST_RUN_B : (c.eol ? ST_EOL : ST_IDLE);
      ST_RUN_B: r = c.eol ? ST_EOL : ST_IDLE;
      ST_EOL:   r = ST_PAD;
      ST_PAD:   r = (c.mode == spre_pkg::MODE_8BIT) ? ST_ZERO8 : ST_CLOSE;
      ST_ZERO8: r = ST_CLOSE;
      default:  r = ST_IDLE;
    endcase
    return r;
  endfunction

  logic [3:0]      st_r, st_nxt;
  spre_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [8:0]      left_r, left_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [6:0]      part_r, part_nxt;
  logic [2:0]      pc_r, pc_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [7:0]      pend_data_r, pend_data_nxt;
  logic            pend_closed_r, pend_closed_nxt;

  spre_pkg::code_t code;
  logic [7:0]      run_col;
  logic            run_ph, put_ph, go;
  logic [7:0]      put_v, vmask;
  logic [3:0]      put_n, nb;
  logic [14:0]     acc;
  logic [2:0]      rem;
  logic            new_vld, new_closed;
  logic [7:0]      new_data;
  logic [6:0]      pk_part;
  logic            code_end, phase_done, cmd_end, take_next;
  logic [3:0]      ph_nxt, first_st;
  logic [8:0]      first_left;

  // Current code for the run phases
  always_comb begin
    run_ph  = (st_r == ST_RUN_A) || (st_r == ST_RUN_B);
    run_col = (st_r == ST_RUN_B) ? cmd_r.b_col : cmd_r.a_col;
    code    = spre_pkg::code_of(cmd_r.mode, run_col, left_r);
  end

  // Select this cycle's bit group
  always_comb begin
    put_v = spre_pkg::PAD_BYTE;
    put_n = 4'd8;
    case (st_r)
      ST_HDR:   put_v = spre_pkg::HDR_BASE + 8'(cmd_r.mode);
      ST_RUN_A,
      ST_RUN_B: begin
        put_v = code.val[k_r];
        put_n = code.nbits[k_r];
      end
      ST_PAD:   put_n = (pc_r == 3'd0) ? 4'd0 : 4'd8 - 4'(pc_r);
      ST_CLOSE: put_v = spre_pkg::EOL_BYTE;
      default:  put_n = 4'd8;
    endcase
  end

  // Pack MSB first; at most one byte completes per group
  always_comb begin
    vmask    = 8'((9'h001 << put_n) - 9'h001);
    acc      = (15'(part_r) << put_n) | 15'(put_v & vmask);
    nb       = 4'(pc_r) + put_n;
    rem      = nb[2:0];
    new_vld  = nb[3];
    new_data = 8'(acc >> rem);
    pk_part  = new_vld ? 7'(acc & ((15'h0001 << rem) - 15'h0001)) : 7'(acc);
    new_closed = (st_r == ST_CLOSE);
  end

  // Entry point of the command at the queue head
  always_comb begin
    first_st   = q_head.hdr ? ST_HDR : next_after(ST_HDR, q_head);
    first_left = (first_st == ST_RUN_B) ? q_head.b_cnt : q_head.a_cnt;
  end

  // Sequence phases, hold back each byte until the next one shows where
  // the pixel's burst ends
  always_comb begin
    st_nxt          = st_r;
    cmd_nxt         = cmd_r;
    left_nxt        = left_r;
    k_nxt           = k_r;
    part_nxt        = part_r;
    pc_nxt          = pc_r;
    pend_vld_nxt    = pend_vld_r;
    pend_data_nxt   = pend_data_r;
    pend_closed_nxt = pend_closed_r;
    q_pop           = 1'b0;
    oq_push         = 1'b0;
    oq_item         = '0;
    take_next       = 1'b0;
    go              = !oq_full;
    put_ph          = (st_r != ST_IDLE) && (st_r != ST_FIN);
    code_end        = (k_r == code.nputs - 2'd1);
    phase_done      = run_ph ? (code_end && (left_r == code.used)) : 1'b1;
    ph_nxt          = next_after(st_r, cmd_r);
    cmd_end         = phase_done && (ph_nxt == ST_IDLE);

    if (st_r == ST_IDLE) begin
      take_next = 1'b1;
    end else if (st_r == ST_FIN) begin
      if (go) begin
        oq_push      = 1'b1;
        oq_item      = '{data: pend_data_r, last: 1'b1, closed: pend_closed_r};
        pend_vld_nxt = 1'b0;
        take_next    = 1'b1;
      end
    end else if (put_ph && go) begin
      part_nxt = pk_part;
      pc_nxt   = nb[2:0];

      // Advance within the run
      if (run_ph) begin
        if (code_end) begin
          k_nxt    = 2'd0;
          left_nxt = left_r - code.used;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end

      // Advance to the next phase
      if (phase_done && !cmd_end) begin
        st_nxt   = ph_nxt;
        k_nxt    = 2'd0;
        left_nxt = (ph_nxt == ST_RUN_B) ? cmd_r.b_cnt : cmd_r.a_cnt;
      end

      // Route the completed byte
      if (new_vld && pend_vld_r) begin
        oq_push         = 1'b1;
        oq_item         = '{data: pend_data_r, last: 1'b0, closed: pend_closed_r};
        pend_data_nxt   = new_data;
        pend_closed_nxt = new_closed;
        if (cmd_end) begin
          st_nxt = ST_FIN;
        end
      end else if (new_vld) begin
        if (cmd_end) begin
          oq_push   = 1'b1;
          oq_item   = '{data: new_data, last: 1'b1, closed: new_closed};
          take_next = 1'b1;
        end else begin
          pend_vld_nxt    = 1'b1;
          pend_data_nxt   = new_data;
          pend_closed_nxt = new_closed;
        end
      end else if (cmd_end) begin
        if (pend_vld_r) begin
          oq_push      = 1'b1;
          oq_item      = '{data: pend_data_r, last: 1'b1, closed: pend_closed_r};
          pend_vld_nxt = 1'b0;
        end
        take_next = 1'b1;
      end
    end

    // Load the next command without a bubble
    if (take_next) begin
      if (!q_empty) begin
        q_pop    = 1'b1;
        cmd_nxt  = q_head;
        st_nxt   = first_st;
        left_nxt = first_left;
        k_nxt    = 2'd0;
      end else begin
        st_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      part_r     <= 7'd0;
      pc_r       <= 3'd0;
      pend_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      part_r     <= part_nxt;
      pc_r       <= pc_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    left_r        <= left_nxt;
    k_r           <= k_nxt;
    pend_data_r   <= pend_data_nxt;
    pend_closed_r <= pend_closed_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/spre_checker.sv]
// ============================================================================
// spre_checker: port-level checks for the encoder
// Watches the top-level ports only; attached to the top level by bind.
// ============================================================================
`default_nettype none

module spre_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_burst_last,
  input wire logic       out_line_closed
);

  // Reset leaves both queues drained
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A line-close byte is always 0xF0
  a_close_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_closed) |-> (out_byte == spre_pkg::EOL_BYTE))
    else $error("line close byte is not 0xF0");

  // A line-close byte always ends its pixel's burst
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_line_closed) |-> out_burst_last)
    else $error("line close byte without burst end");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_byte) && $stable(out_burst_last)
       && $stable(out_line_closed)))
    else $error("waiting result changed before pop");

endmodule

bind subtitle_pixel_rle_encoder spre_checker u_spre_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_byte        (out_byte),
  .out_burst_last  (out_burst_last),
  .out_line_closed (out_line_closed)
);

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Subtitle pixel run-length encoder testbench
// Drives palette-index pixels, line by line, into the encoder in every code
// mode and checks each output byte and its flags against a cycle-free model
// of the DVB pixel-data stream, under random input and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 55;
  localparam int MAX_BURST     = 12;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       closed;
  } enc_byte_t;

  // Model of the encoder: run tracking, code choice and bit packing
  class pixel_stream_predictor;
    logic [1:0]  depth_mode;
    logic [7:0]  run_colour;
    int unsigned run_len;
    bit          line_open;
    int unsigned pend_bits;
    int unsigned pend_cnt;
    enc_byte_t   expected_bytes[$];
    enc_byte_t   burst[$];
    int          errors;

    function new();
      depth_mode = spre_pkg::MODE_RESET;
      run_colour = '0;
      run_len    = 0;
      line_open  = 0;
      pend_bits  = 0;
      pend_cnt   = 0;
      errors     = 0;
    endfunction

    function logic [1:0] eff_mode();
      return (depth_mode >= spre_pkg::MODE_8BIT) ? spre_pkg::MODE_8BIT : depth_mode;
    endfunction

    // Drop mode writes while a line is open
    function void write_mode(logic [1:0] v);
      if (!line_open) depth_mode = v;
    endfunction

    function void push_byte(logic [7:0] b, logic closed);
      enc_byte_t e;
      e.data   = b;
      e.last   = 1'b0;
      e.closed = closed;
      if (burst.size() < MAX_BURST) burst.push_back(e);
    endfunction

    // Append n code bits MSB first, emit each completed byte
    function void put_bits(int unsigned value, int unsigned n);
      int unsigned acc;
      int unsigned nb;
      acc = (pend_bits << n) | (value & ((1 << n) - 1));
      nb  = pend_cnt + n;
      while (nb >= 8) begin
        push_byte(8'(acc >> (nb - 8)), 1'b0);
        nb  = nb - 8;
        acc = acc & ((1 << nb) - 1);
      end
      pend_bits = acc & 32'h7F;
      pend_cnt  = nb & 7;
    endfunction

    function int unsigned code_2bit(int unsigned c, int unsigned len);
      if (len >= 29) begin
        put_bits(spre_pkg::CODE2_LONG, 6); put_bits(len - 29, 8); put_bits(c, 2);
        return len;
      end
      if (len >= 12 && len <= 27) begin
        put_bits(spre_pkg::CODE2_MID, 6); put_bits(len - 12, 4); put_bits(c, 2);
        return len;
      end
      if (len >= 3 && len <= 10) begin
        put_bits(0, 2); put_bits(8 + len - 3, 4); put_bits(c, 2);
        return len;
      end
      if (c != 0) begin
        put_bits(c, 2);
        return 1;
      end
      if (len == 2) begin
        put_bits(spre_pkg::CODE2_ONE, 6);
        return 2;
      end
      put_bits(spre_pkg::CODE2_ONE, 4);
      return 1;
    endfunction

    function int unsigned code_4bit(int unsigned c, int unsigned len);
      int unsigned l;
      if (c == 0 && len >= 3 && len <= 9) begin
        put_bits(0, 4); put_bits(len - 2, 4);
        return len;
      end
      if (len >= 4 && len < 25) begin
        l = (len > 7) ? 7 : len;
        put_bits(0, 4); put_bits(8 + l - 4, 4); put_bits(c, 4);
        return l;
      end
      if (len >= 25) begin
        put_bits(spre_pkg::CODE4_LONG, 8); put_bits(len - 25, 8); put_bits(c, 4);
        return len;
      end
      if (c != 0) begin
        put_bits(c, 4);
        return 1;
      end
      if (len > 1) begin
        put_bits(spre_pkg::CODE4_TWO_ZERO, 8);
        return 2;
      end
      put_bits(spre_pkg::CODE4_ONE_ZERO, 8);
      return 1;
    endfunction

    function int unsigned code_8bit(int unsigned c, int unsigned len);
      if (len == 1 && c != 0) begin
        put_bits(c, 8);
        return 1;
      end
      if (c == 0) begin
        put_bits(0, 8); put_bits(len, 8);
        return len;
      end
      if (len > 2) begin
        put_bits(0, 8); put_bits(spre_pkg::CODE8_COLOUR | len, 8); put_bits(c, 8);
        return len;
      end
      put_bits(c, 8);
      put_bits(c, 8);
      return 2;
    endfunction

    // Split the open run greedily into codes
    function void flush_run(logic [1:0] mode);
      int unsigned left;
      int unsigned used;
      left = run_len;
      while (left > 0) begin
        if (mode == spre_pkg::MODE_2BIT) used = code_2bit(run_colour, left);
        else if (mode == spre_pkg::MODE_4BIT) used = code_4bit(run_colour, left);
        else used = code_8bit(run_colour, left);
        if (used == 0 || used > left) used = left;
        left = left - used;
      end
      run_len = 0;
    endfunction

    // Note one accepted pixel and queue the bytes it completes
    function void note_pixel(logic [7:0] pixel, logic line_end);
      logic [1:0]  mode;
      int unsigned cap;
      logic [7:0]  p;
      mode = eff_mode();
      p    = pixel;
      burst.delete();
      case (mode)
        spre_pkg::MODE_2BIT: begin
          cap = spre_pkg::CAP_2BIT;
          p   = p & 8'h03;
        end
        spre_pkg::MODE_4BIT: begin
          cap = spre_pkg::CAP_4BIT;
          p   = p & 8'h0F;
        end
        default: cap = spre_pkg::CAP_8BIT;
      endcase

      // Open a line with its data-type byte
      if (!line_open) begin
        push_byte(spre_pkg::HDR_BASE | 8'(mode), 1'b0);
        line_open = 1;
        run_len   = 0;
        pend_bits = 0;
        pend_cnt  = 0;
      end
      if (run_len > 0 && p != run_colour) flush_run(mode);
      run_colour = p;
      run_len    = run_len + 1;
      if (run_len >= cap) flush_run(mode);

      // Close the line: end-of-string, padding, an 8-bit mode zero byte, end-of-line byte
      if (line_end) begin
        if (run_len > 0) flush_run(mode);
        put_bits(spre_pkg::PAD_BYTE, 8);
        if (pend_cnt > 0) put_bits(0, 8 - pend_cnt);
        if (mode == spre_pkg::MODE_8BIT) put_bits(spre_pkg::PAD_BYTE, 8);
        push_byte(spre_pkg::EOL_BYTE, 1'b1);
        line_open = 0;
        pend_bits = 0;
        pend_cnt  = 0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
    endfunction

    // Compare one popped byte with the oldest expectation
    function void check_byte(logic [7:0] b, logic last, logic closed);
      enc_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("out_byte 0x%02h popped with nothing expected", b);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.data) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, b);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_burst_last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (closed !== e.closed) begin
        $error("out_line_closed: expected %0b, actual %0b", e.closed, closed);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic [7:0] in_pixel = 8'h00;
  logic       in_line_end = 1'b0;
  logic       out_pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_depth_mode = 2'd0;
  logic       in_full;
  logic       out_empty;
  logic [7:0] out_byte;
  logic       out_burst_last;
  logic       out_line_closed;
  logic       cfg_ready;

  pixel_stream_predictor board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int random_items = 0;

  subtitle_pixel_rle_encoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_pixel        (in_pixel),
    .in_line_end     (in_line_end),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_burst_last  (out_burst_last),
    .out_line_closed (out_line_closed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_depth_mode  (cfg_depth_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive pop at the falling edge; hold off for a long stretch on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_pop = 1'b0;
    end else if (hold_left > 0) begin
      out_pop   = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each popped byte
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      board.check_byte(out_byte, out_burst_last, out_line_closed);
  end

  // Offer one pixel, idle at random first, wait for acceptance
  task automatic send_pixel(input logic [7:0] pix, input logic line_end);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push     = 1'b1;
    in_pixel    = pix;
    in_line_end = line_end;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_pixel(pix, line_end);
  endtask

  // Send n pixels of one colour, with random bits above the mode's width
  task automatic send_run(input logic [7:0] colour, input int n, input bit close_line);
    logic [7:0] pix;
    for (int i = 0; i < n; i++) begin
      case (board.eff_mode())
        spre_pkg::MODE_2BIT: pix = (8'($urandom) & 8'hFC) | (colour & 8'h03);
        spre_pkg::MODE_4BIT: pix = (8'($urandom) & 8'hF0) | (colour & 8'h0F);
        default:             pix = colour;
      endcase
      send_pixel(pix, close_line && (i == n - 1));
    end
  endtask

  // Stop offering, wait for every expected byte, let quiet work finish
  task automatic drain_and_settle();
    @(negedge clk);
    in_push = 1'b0;
    while (board.expected_bytes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(input logic [1:0] v);
    drain_and_settle();
    @(negedge clk);
    cfg_valid      = 1'b1;
    cfg_depth_mode = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_mode(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One line of random runs, sometimes with an ignored mode write inside it
  task automatic send_random_line(input int max_len);
    int         len;
    int         done;
    int         run;
    int         pick;
    logic [7:0] colour;
    bit         mid_write;
    len       = $urandom_range(1, max_len);
    done      = 0;
    mid_write = ($urandom_range(7) == 0);
    while (done < len) begin
      colour = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
      pick   = $urandom_range(9);
      if (pick <= 5) run = $urandom_range(1, 4);
      else if (pick <= 8) run = $urandom_range(5, 30);
      else run = $urandom_range(31, 140);
      if (run > len - done) run = len - done;
      if (mid_write && done > 0 && done >= len / 2) begin
        write_depth(2'($urandom_range(0, 3)));
        mid_write = 0;
      end
      send_run(colour, run, (done + run) == len);
      done         = done + run;
      random_items = random_items + run;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: 8-bit mode after reset
    send_run(8'hFF, 2, 0);
    send_run(8'h00, 3, 0);
    send_run(8'h7F, 1, 1);
    send_run(8'h00, 1, 1);
    // mode write while a line is open is dropped
    send_run(8'h01, 1, 0);
    write_depth(spre_pkg::MODE_2BIT);
    send_run(8'h01, 1, 0);
    send_run(8'h02, 1, 1);
    // 2-bit mode: run of eleven, zero pair, masked high bits
    write_depth(spre_pkg::MODE_2BIT);
    send_run(8'h03, 11, 0);
    send_run(8'h00, 2, 0);
    send_run(8'h01, 1, 1);
    // 4-bit mode: single zero, then a colour
    write_depth(spre_pkg::MODE_4BIT);
    send_run(8'h00, 1, 0);
    send_run(8'h05, 1, 1);

    // Random phases: receiver-heavy idling, sender-heavy idling, none
    for (int phase = 0; phase < 3; phase++) begin
      int goal;
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 68;
          write_depth(spre_pkg::MODE_2BIT);
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 37;
          write_depth(spre_pkg::MODE_4BIT);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // unused mode code falls back to 8-bit
          write_depth(spre_pkg::MODE_SPARE);
          hold_req = 1;
          // reach the cap, then start a new run of the same colour
          send_run(8'($urandom | 8'h01), spre_pkg::CAP_8BIT + 1, 1);
        end
      endcase
      goal = random_items + PHASE_ITEMS;
      while (random_items < goal) begin
        send_random_line(60);
        if ($urandom_range(3) == 0) write_depth(2'($urandom_range(0, 3)));
      end
    end

    drain_and_settle();
    if (board.errors == 0 && board.expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #12ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[subtitle_pixel_rle_encoder.f]
hw/rtl/spre_pkg.sv
hw/rtl/spre_front.sv
hw/rtl/spre_cmdq.sv
hw/rtl/spre_outq.sv
hw/rtl/spre_back.sv
hw/rtl/subtitle_pixel_rle_encoder.sv
hw/rtl/spre_checker.sv
tb/sv/testbench.sv
